// ===== rtl/pvpe_pkg.sv =====
// ----------------------------------------------------------------------------
// pvpe_pkg
// Shared types, constants and helper functions of the pseudo-Voigt peak
// evaluation unit.
// ----------------------------------------------------------------------------
package pvpe_pkg;

  localparam int unsigned EXP_FRAC_BITS = 20;

  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [31:0] HEIGHT_RESET = 32'd65536;
  localparam logic [31:0] CENTER_RESET = 32'd0;
  localparam logic [30:0] WIDTH_RESET  = 31'd65536;
  localparam logic [16:0] SHAPE_RESET  = 17'd32768;
  localparam logic [16:0] ETA_ONE      = 17'd65536;

  typedef enum logic [1:0] {
    REG_HEIGHT,
    REG_CENTER,
    REG_WIDTH,
    REG_SHAPE
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] value;
    logic [16:0] d_height;
    logic [31:0] d_center;
    logic [31:0] d_width;
    logic [31:0] d_shape;
    logic [31:0] slope;
  } res_t;

  // 2^(-2^-idx) in Q0.30 by repeated integer square roots
  function automatic logic [29:0] exp_coef(int unsigned idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    c = 64'd1 << 29;
    for (int unsigned i = 1; i <= EXP_FRAC_BITS; i++) begin
      if (i <= idx) begin
        v   = c << 30;
        res = 64'd0;
        for (int k = 31; k >= 0; k--) begin
          bit_w = 64'd1 << (2 * k);
          if (v >= res + bit_w) begin
            v   = v - (res + bit_w);
            res = (res >> 1) + bit_w;
          end else begin
            res = res >> 1;
          end
        end
        c = res;
      end
    end
    return c[29:0];
  endfunction

  // apply sign to a magnitude and saturate to 32 bit signed
  function automatic logic [31:0] sat32(logic neg, logic [32:0] mag);
    logic [32:0] m;
    m = (mag > 33'h080000000) ? 33'h080000000 : mag;
    if (!neg) begin
      return (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return ~m[31:0] + 32'd1;
  endfunction

endpackage

// ===== rtl/pvpe_div.sv =====
// ----------------------------------------------------------------------------
// pvpe_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband that travels alongside. The upper dividend part must be below
// the divisor.
// ----------------------------------------------------------------------------
module pvpe_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] lo_q   [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          v_q    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_hi_i;
      assign lo_in   = num_lo_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign v_in    = in_valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign trial = {rem_in, lo_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        lo_q[k]   <= {lo_in[QW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid_o = v_q[QW-1];
  assign quo_o       = lo_q[QW-1];
  assign side_o      = side_q[QW-1];

endmodule

// ===== rtl/pvpe_exp.sv =====
// ----------------------------------------------------------------------------
// pvpe_exp
// Pipelined 2^(-s) for s in Q32.32, result in Q1.30: one rounded multiply
// for each of the upper 20 fraction bits, then the integer shift.
// ----------------------------------------------------------------------------
module pvpe_exp #(
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  logic [63:0]   s_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  output logic [30:0]   ex_o,
  output logic [63:0]   s_o,
  output logic [SW-1:0] side_o
);
  import pvpe_pkg::*;

  logic [30:0]   r_q    [EXP_FRAC_BITS];
  logic [63:0]   s_q    [EXP_FRAC_BITS];
  logic [SW-1:0] side_q [EXP_FRAC_BITS];
  logic          v_q    [EXP_FRAC_BITS];

  for (genvar k = 0; k < EXP_FRAC_BITS; k++) begin : g_stage
    localparam logic [29:0] Coef = exp_coef(k + 1);
    logic [30:0]   r_in;
    logic [63:0]   s_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [60:0]   prod;

    if (k == 0) begin : g_first
      assign r_in    = 31'h40000000;
      assign s_in    = s_i;
      assign side_in = side_i;
      assign v_in    = in_valid_i;
    end else begin : g_next
      assign r_in    = r_q[k-1];
      assign s_in    = s_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign prod = 61'(r_in) * 61'(Coef) + (61'd1 << 29);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= s_in[31-k] ? 31'(prod >> 30) : r_in;
        s_q[k]    <= s_in;
        side_q[k] <= side_in;
      end
    end
  end

  logic [30:0]   ex_q;
  logic [63:0]   sf_q;
  logic [SW-1:0] sidef_q;
  logic          vf_q;
  logic          n_big;
  logic [63:0]   s_last;

  assign s_last = s_q[EXP_FRAC_BITS-1];
  assign n_big  = (|s_last[63:37]) || (s_last[36:32] == 5'd31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= v_q[EXP_FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q    <= n_big ? 31'd0 : (r_q[EXP_FRAC_BITS-1] >> s_last[36:32]);
      sf_q    <= s_last;
      sidef_q <= side_q[EXP_FRAC_BITS-1];
    end
  end

  assign out_valid_o = vf_q;
  assign ex_o        = ex_q;
  assign s_o         = sf_q;
  assign side_o      = sidef_q;

endmodule

// ===== rtl/pvpe_skid.sv =====
// ----------------------------------------------------------------------------
// pvpe_skid
// Output register with one skid entry; freezes the pipeline only when both
// are full.
// ----------------------------------------------------------------------------
module pvpe_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pipe_valid_i,
  input  pvpe_pkg::res_t pipe_data_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output pvpe_pkg::res_t out_data_o,
  output logic           en_o
);
  import pvpe_pkg::*;

  logic out_v_q;
  logic skid_v_q;
  res_t out_q;
  res_t skid_q;
  logic take;
  logic load;

  assign en_o = !skid_v_q;
  assign take = pipe_valid_i && en_o;
  assign load = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load) begin
      out_v_q  <= skid_v_q || take;
      skid_v_q <= 1'b0;
    end else if (take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= skid_v_q ? skid_q : pipe_data_i;
    end else if (take) begin
      skid_q <= pipe_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pseudo_voigt_peak_eval_unit.sv =====
// ----------------------------------------------------------------------------
// pseudo_voigt_peak_eval_unit
// Main blocks: bit-serial dividers in series (32 + 31 + 32 stages, the last
// pair in parallel), 21-stage exponential, output register and skid entry.
// Throughput: one request per cycle while in_stall_o is low.
// Reset: valid bits cleared, configuration back to its defaults.
// ----------------------------------------------------------------------------
module pseudo_voigt_peak_eval_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [16:0] d_height_o,
  output logic [31:0] d_center_o,
  output logic [31:0] d_width_o,
  output logic [31:0] d_shape_o,
  output logic [31:0] slope_o
);
  import pvpe_pkg::*;

  localparam int unsigned NMID = 12;

  typedef struct packed {
    logic        tneg;
    logic [31:0] tm;
    logic [30:0] lor;
    logic [30:0] ex;
    logic [47:0] pl;
    logic [30:0] p30;
    logic [30:0] ll;
    logic [30:0] gl;
    logic        dneg;
    logic [30:0] diffm;
    logic [47:0] ql;
    logic [30:0] q30;
    logic [31:0] val_m;
    logic [31:0] a;
    logic [46:0] b;
    logic [63:0] plo;
    logic [46:0] n;
    logic [31:0] shp_m;
  } mid_t;

  // configuration
  logic [31:0] height_q;
  logic [31:0] center_q;
  logic [30:0] width_q;
  logic [16:0] shape_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RESET;
      center_q <= CENTER_RESET;
      width_q  <= WIDTH_RESET;
      shape_q  <= SHAPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_CENTER: center_q <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[30:0];
        REG_SHAPE:  shape_q  <= cfg_data_i[16:0];
        default:    height_q <= height_q;
      endcase
    end
  end

  logic        hneg;
  logic [31:0] hm;
  logic [30:0] w_eff;
  logic [16:0] eta;
  logic [16:0] etac;

  assign hneg  = height_q[31];
  assign hm    = hneg ? (~height_q + 32'd1) : height_q;
  assign w_eff = (width_q == 31'd0) ? 31'd1 : width_q;
  assign eta   = (shape_q > ETA_ONE) ? ETA_ONE : shape_q;
  assign etac  = ETA_ONE - eta;

  logic en;

  // input stage: distance to center
  logic [32:0] diff_d;
  logic [32:0] dm1_q;
  logic        tneg1_q;
  logic        v1_q;

  assign diff_d = {position_i[31], position_i} - {center_q[31], center_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm1_q   <= diff_d[32] ? (~diff_d + 33'd1) : diff_d;
      tneg1_q <= diff_d[32];
    end
  end

  // |t| = |d| * 2^16 / w
  logic        ovf_t;
  logic        tdiv_v;
  logic [31:0] tdiv_q;
  logic [1:0]  tdiv_side;

  assign ovf_t = {14'd0, dm1_q[32:16]} >= w_eff;

  pvpe_div #(.DW(31), .QW(32), .SW(2)) u_div_t (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .in_valid_i  (v1_q),
    .num_hi_i    ({14'd0, dm1_q[32:16]}),
    .num_lo_i    ({dm1_q[15:0], 16'd0}),
    .den_i       (w_eff),
    .side_i      ({ovf_t, tneg1_q}),
    .out_valid_o (tdiv_v),
    .quo_o       (tdiv_q),
    .side_o      (tdiv_side)
  );

  logic [31:0] tm2_q;
  logic        tneg2_q;
  logic        v2_q;
  logic [63:0] s3_q;
  logic [31:0] tm3_q;
  logic        tneg3_q;
  logic        v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v2_q <= tdiv_v;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tm2_q   <= (tdiv_side[1] || tdiv_q > 32'h80000000) ? 32'h80000000 : tdiv_q;
      tneg2_q <= tdiv_side[0];
      s3_q    <= 64'(tm2_q) * 64'(tm2_q);
      tm3_q   <= tm2_q;
      tneg3_q <= tneg2_q;
    end
  end

  // gaussian part
  logic        exp_v;
  logic [30:0] exp_ex;
  logic [63:0] exp_s;
  logic [32:0] exp_side;

  pvpe_exp #(.SW(33)) u_exp (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .in_valid_i  (v3_q),
    .s_i         (s3_q),
    .side_i      ({tm3_q, tneg3_q}),
    .out_valid_o (exp_v),
    .ex_o        (exp_ex),
    .s_o         (exp_s),
    .side_o      (exp_side)
  );

  // lorentzian part: 2^62 / (2^32 + s)
  logic        ldiv_v;
  logic [30:0] ldiv_q;
  logic [63:0] ldiv_side;

  pvpe_div #(.DW(63), .QW(31), .SW(64)) u_div_l (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .in_valid_i  (exp_v),
    .num_hi_i    (63'h80000000),
    .num_lo_i    (31'd0),
    .den_i       (exp_s[62:0] + (63'd1 << 32)),
    .side_i      ({exp_ex, exp_side}),
    .out_valid_o (ldiv_v),
    .quo_o       (ldiv_q),
    .side_o      (ldiv_side)
  );

  // mixing and products
  mid_t m_src;
  mid_t m_d [NMID];
  mid_t m_q [NMID];
  logic mv_q [NMID];
  logic [47:0] p_sum;
  logic [47:0] q_sum;
  logic [61:0] ll_prod;
  logic [60:0] gl_prod;
  logic [62:0] val_prod;
  logic [62:0] a_prod;
  logic [63:0] b_prod;
  logic [78:0] bt;
  logic [62:0] shp_prod;

  always_comb begin
    m_src      = '0;
    m_src.lor  = ldiv_q;
    m_src.ex   = ldiv_side[63:33];
    m_src.tm   = ldiv_side[32:1];
    m_src.tneg = ldiv_side[0];

    m_d[0]    = m_src;
    m_d[0].pl = 48'(eta) * 48'(m_src.lor);

    m_d[1]     = m_q[0];
    p_sum      = m_q[0].pl + 48'(etac) * 48'(m_q[0].ex) + 48'd32768;
    m_d[1].p30 = 31'(p_sum >> 16);

    m_d[2]    = m_q[1];
    ll_prod   = 62'(m_q[1].lor) * 62'(m_q[1].lor) + (62'd1 << 29);
    m_d[2].ll = 31'(ll_prod >> 30);

    m_d[3]       = m_q[2];
    gl_prod      = 61'(m_q[2].ex) * 61'(LN2_Q30) + (61'd1 << 29);
    m_d[3].gl    = 31'(gl_prod >> 30);
    m_d[3].dneg  = m_q[2].lor < m_q[2].ex;
    m_d[3].diffm = (m_q[2].lor < m_q[2].ex) ? (m_q[2].ex - m_q[2].lor)
                                            : (m_q[2].lor - m_q[2].ex);

    m_d[4]    = m_q[3];
    m_d[4].ql = 48'(eta) * 48'(m_q[3].ll);

    m_d[5]     = m_q[4];
    q_sum      = m_q[4].ql + 48'(etac) * 48'(m_q[4].gl) + 48'd32768;
    m_d[5].q30 = 31'(q_sum >> 16);

    m_d[6]       = m_q[5];
    val_prod     = 63'(hm) * 63'(m_q[5].p30) + (63'd1 << 29);
    m_d[6].val_m = 32'(val_prod >> 30);

    m_d[7]   = m_q[6];
    a_prod   = 63'(hm) * 63'(m_q[6].q30) + (63'd1 << 29);
    m_d[7].a = 32'(a_prod >> 30);

    m_d[8]   = m_q[7];
    b_prod   = 64'(m_q[7].a) * 64'(m_q[7].tm);
    m_d[8].b = b_prod[62:16];

    m_d[9]     = m_q[8];
    m_d[9].plo = 64'(m_q[8].b[31:0]) * 64'(m_q[8].tm);

    m_d[10]   = m_q[9];
    bt        = 79'(m_q[9].plo)
              + (79'(47'(m_q[9].b[46:32]) * 47'(m_q[9].tm)) << 32);
    m_d[10].n = (bt[78:16] > 63'h400000000000) ? 47'h400000000000 : bt[62:16];

    m_d[11]       = m_q[10];
    shp_prod      = 63'(hm) * 63'(m_q[10].diffm) + (63'd1 << 29);
    m_d[11].shp_m = 32'(shp_prod >> 30);
  end

  for (genvar k = 0; k < NMID; k++) begin : g_mid
    logic v_in;
    if (k == 0) begin : g_first
      assign v_in = ldiv_v;
    end else begin : g_next
      assign v_in = mv_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[k] <= 1'b0;
      end else if (en) begin
        mv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[k] <= m_d[k];
      end
    end
  end

  // derivatives by center and width
  mid_t        m_last;
  logic        ovf_c;
  logic        ovf_w;
  logic        cdiv_v;
  logic [31:0] cdiv_q;
  logic [97:0] cdiv_side;
  logic        wdiv_v;
  logic [31:0] wdiv_q;
  logic        wdiv_side;

  assign m_last = m_q[NMID-1];
  assign ovf_c  = m_last.b[46:15] >= {1'b0, w_eff};
  assign ovf_w  = m_last.n[46:15] >= {1'b0, w_eff};

  pvpe_div #(.DW(31), .QW(32), .SW(98)) u_div_c (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .in_valid_i  (mv_q[NMID-1]),
    .num_hi_i    (m_last.b[45:15]),
    .num_lo_i    ({m_last.b[14:0], 17'd0}),
    .den_i       (w_eff),
    .side_i      ({ovf_c, m_last.tneg, m_last.dneg, m_last.val_m,
                   m_last.p30, m_last.shp_m}),
    .out_valid_o (cdiv_v),
    .quo_o       (cdiv_q),
    .side_o      (cdiv_side)
  );

  pvpe_div #(.DW(31), .QW(32), .SW(1)) u_div_w (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .in_valid_i  (mv_q[NMID-1]),
    .num_hi_i    (m_last.n[45:15]),
    .num_lo_i    ({m_last.n[14:0], 17'd0}),
    .den_i       (w_eff),
    .side_i      (ovf_w),
    .out_valid_o (wdiv_v),
    .quo_o       (wdiv_q),
    .side_o      (wdiv_side)
  );

  // final signs and saturation
  logic        f_ovf_c;
  logic        f_tneg;
  logic        f_dneg;
  logic [31:0] f_val_m;
  logic [30:0] f_p30;
  logic [31:0] f_shp_m;
  logic [32:0] dcm;
  logic [32:0] dwm;
  logic [30:0] dh_sum;
  res_t        fin_d;
  res_t        fin_q;
  logic        fin_v_q;

  assign {f_ovf_c, f_tneg, f_dneg, f_val_m, f_p30, f_shp_m} = cdiv_side;

  always_comb begin
    dcm              = f_ovf_c ? 33'h100000000 : {1'b0, cdiv_q};
    dwm              = wdiv_side ? 33'h100000000 : {1'b0, wdiv_q};
    dh_sum           = f_p30 + 31'd8192;
    fin_d.value      = sat32(hneg, {1'b0, f_val_m});
    fin_d.d_height   = dh_sum[30:14];
    fin_d.d_center   = sat32(hneg ^ f_tneg, dcm);
    fin_d.d_width    = sat32(hneg, dwm);
    fin_d.d_shape    = sat32(hneg ^ f_dneg, {1'b0, f_shp_m});
    fin_d.slope      = sat32((hneg == f_tneg) && (dcm != 33'd0), dcm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= cdiv_v && wdiv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  res_t out_data;

  pvpe_skid u_skid (
    .clk_i,
    .rst_ni,
    .pipe_valid_i (fin_v_q),
    .pipe_data_i  (fin_q),
    .out_stall_i,
    .out_valid_o,
    .out_data_o   (out_data),
    .en_o         (en)
  );

  assign in_stall_o = !en;
  assign value_o    = out_data.value;
  assign d_height_o = out_data.d_height;
  assign d_center_o = out_data.d_center;
  assign d_width_o  = out_data.d_width;
  assign d_shape_o  = out_data.d_shape;
  assign slope_o    = out_data.slope;

endmodule

// ===== rtl/pvpe_chk.sv =====
// ----------------------------------------------------------------------------
// pvpe_chk
// Port-level checks of the pseudo-Voigt peak evaluation unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module pvpe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] position_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o,
  input logic [16:0] d_height_o,
  input logic [31:0] d_center_o,
  input logic [31:0] d_width_o,
  input logic [31:0] d_shape_o,
  input logic [31:0] slope_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(slope_o))
    else $error("stalled result changed");

  a_dh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> d_height_o <= 17'd65536)
    else $error("unit profile above one");

  a_slope_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && d_center_o != 32'h80000000 && d_center_o != 32'h7FFFFFFF
    |-> slope_o == (~d_center_o + 32'd1))
    else $error("slope is not the negated center derivative");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind pseudo_voigt_peak_eval_unit pvpe_chk u_pvpe_chk (.*);
